// ===== hdl/piecewise_linear_table_interp_defines.svh =====
// assertion macros used by the interpolator sequencer
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define PLTI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plti same-cycle check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define PLTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plti next-cycle check failed");

`endif

// ===== hdl/plti_pkg.sv =====
// types and constants of the interpolation table block
package plti_pkg;

	localparam int VAL_W    = 32;
	localparam int IDX_W    = 6;
	localparam int PC_W     = 7;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd2;

	localparam logic [PADDR_W-1:0] ADDR_POINT_COUNT = 2'd0;
	localparam logic [PC_W-1:0]    PC_RESET         = 7'd2;

	// one quotient bit per step
	localparam int DIV_STEPS = VAL_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                    opcode;
		logic [IDX_W-1:0]        entry_index;
		logic signed [VAL_W-1:0] entry_position;
		logic signed [VAL_W-1:0] entry_first_value;
		logic signed [VAL_W-1:0] entry_second_value;
		logic signed [VAL_W-1:0] query_position;
	} in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] first_result;
		logic signed [VAL_W-1:0] second_result;
		logic [STATUS_W-1:0]     status;
	} out_t;

	typedef struct packed {
		logic wr_entry;
		logic load_query;
		logic search;
		logic set_below;
		logic set_above;
		logic prep;
		logic absv;
		logic mul1;
		logic mul2;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic first;
		logic last;
	} dp_stat_t;

endpackage

// ===== hdl/plti_ctrl.sv =====
// sequencer for table writes, breakpoint scan, multiply and divide
`include "piecewise_linear_table_interp_defines.svh"

module plti_ctrl
	import plti_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       is_query,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_ABSV = 3'd3;
	localparam logic [2:0] ST_MUL1 = 3'd4;
	localparam logic [2:0] ST_MUL2 = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]        state_q, state_n;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              div_last;

	assign div_last = (div_cnt_q == DCNT_W'(DIV_STEPS - 1));
	assign busy     = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (is_query) begin
						cmd.load_query = 1'b1;
						state_n        = ST_SRCH;
					end else begin
						cmd.wr_entry = 1'b1;
					end
				end
			end
			ST_SRCH: begin
				cmd.search = 1'b1;
				priority if (stat.hit && stat.first) begin
					cmd.set_below = 1'b1;
					state_n       = ST_FIN;
				end else if (stat.hit) begin
					state_n = ST_PREP;
				end else if (stat.last) begin
					cmd.set_above = 1'b1;
					state_n       = ST_FIN;
				end else begin
					// no breakpoint above the query yet, keep scanning
					state_n = ST_SRCH;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_n  = ST_ABSV;
			end
			ST_ABSV: begin
				cmd.absv = 1'b1;
				state_n  = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_n    = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.mul2) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end
		end
	end

	`PLTI_ASSERT_NEXT(a_query_goes_busy, start && !busy && is_query, busy)
	`PLTI_ASSERT_SAME(a_accept_only_idle, cmd.load_query || cmd.wr_entry, state_q == ST_IDLE)
	`PLTI_ASSERT_NEXT(a_div_ends_in_fin, state_q == ST_DIV && div_last, state_q == ST_FIN)
	`PLTI_ASSERT_NEXT(a_fin_returns_idle, state_q == ST_FIN, state_q == ST_IDLE)

endmodule

// ===== hdl/plti_dpath.sv =====
// breakpoint memory, scan compare, shared multiplier and two divider lanes
module plti_dpath
	import plti_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int AW         = $clog2(MAX_POINTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  in_t           item,
	input  ctrl_cmd_t     cmd,
	input  logic [AW-1:0] last_idx,
	output dp_stat_t      stat,
	output out_t          result,
	output logic          result_valid
);

	localparam int LANES = 2;

	typedef struct packed {
		logic signed [VAL_W-1:0] pos;
		logic signed [VAL_W-1:0] v1;
		logic signed [VAL_W-1:0] v2;
	} entry_t;

	entry_t mem [MAX_POINTS];

	entry_t                  rdata_q, prev_q;
	logic [AW-1:0]           k_q, k_inc, raddr, widx;
	logic [31:0]             widx_ext;
	logic                    wr_ok, rd_en;
	logic signed [VAL_W-1:0] q_q;
	logic [VAL_W-1:0]        delta_q, gap_q;
	logic [VAL_W-1:0]        v0_q   [LANES];
	logic signed [VAL_W:0]   dv_q   [LANES];
	logic [VAL_W-1:0]        a_q    [LANES];
	logic                    neg_q  [LANES];
	logic [VAL_W-1:0]        rem_q  [LANES];
	logic [VAL_W-1:0]        num_q  [LANES];
	logic [STATUS_W-1:0]     status_q;
	out_t                    result_q;
	logic                    result_valid_q;

	logic [VAL_W-1:0]        lo_v   [LANES];
	logic [VAL_W-1:0]        hi_v   [LANES];
	logic [VAL_W:0]          neg_dv [LANES];
	logic [VAL_W-1:0]        abs_a  [LANES];
	logic [VAL_W:0]          trial  [LANES];
	logic [VAL_W:0]          diff   [LANES];
	logic [VAL_W-1:0]        rem_n  [LANES];
	logic [VAL_W-1:0]        num_n  [LANES];
	logic [VAL_W-1:0]        res_v  [LANES];
	logic [2*VAL_W-1:0]      mul_p;

	// table write address and range check
	assign widx_ext = 32'(item.entry_index);
	assign wr_ok    = (widx_ext < 32'(MAX_POINTS));
	assign widx     = widx_ext[AW-1:0];

	// scan read: entry 0 on a new query, then the next entry while no hit
	assign k_inc = k_q + AW'(1);
	assign raddr = cmd.load_query ? '0 : k_inc;
	assign rd_en = cmd.load_query || (cmd.search && !stat.hit);

	assign stat.hit   = ($signed(rdata_q.pos) > q_q);
	assign stat.first = (k_q == '0);
	assign stat.last  = (k_q == last_idx);

	always_ff @(posedge clk) begin
		if (cmd.wr_entry && wr_ok) begin
			mem[widx] <= '{pos: item.entry_position, v1: item.entry_first_value,
				v2: item.entry_second_value};
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_comb begin
		lo_v[0] = prev_q.v1;
		lo_v[1] = prev_q.v2;
		hi_v[0] = rdata_q.v1;
		hi_v[1] = rdata_q.v2;
		for (int l = 0; l < LANES; l++) begin
			neg_dv[l] = -dv_q[l];
			abs_a[l]  = dv_q[l][VAL_W] ? neg_dv[l][VAL_W-1:0] : dv_q[l][VAL_W-1:0];
			// restoring divide step, remainder stays below the gap
			trial[l]  = {rem_q[l], num_q[l][VAL_W-1]};
			diff[l]   = trial[l] - {1'b0, gap_q};
			rem_n[l]  = (trial[l] >= {1'b0, gap_q}) ? diff[l][VAL_W-1:0] : trial[l][VAL_W-1:0];
			num_n[l]  = {num_q[l][VAL_W-2:0], (trial[l] >= {1'b0, gap_q})};
			// quotient is below |dv| so the sum never leaves the 32-bit range
			res_v[l]  = neg_q[l] ? (v0_q[l] - num_q[l]) : (v0_q[l] + num_q[l]);
		end
		mul_p = 64'(delta_q) * 64'(cmd.mul1 ? a_q[0] : a_q[1]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			q_q <= item.query_position;
			k_q <= '0;
		end else if (cmd.search && !stat.hit) begin
			k_q    <= k_inc;
			prev_q <= rdata_q;
		end
		if (cmd.prep) begin
			delta_q <= q_q - prev_q.pos;
			gap_q   <= rdata_q.pos - prev_q.pos;
			for (int l = 0; l < LANES; l++) begin
				v0_q[l] <= lo_v[l];
				dv_q[l] <= $signed({hi_v[l][VAL_W-1], hi_v[l]}) -
					$signed({lo_v[l][VAL_W-1], lo_v[l]});
			end
		end
		if (cmd.absv) begin
			for (int l = 0; l < LANES; l++) begin
				a_q[l]   <= abs_a[l];
				neg_q[l] <= dv_q[l][VAL_W];
			end
		end
		if (cmd.mul1) begin
			rem_q[0] <= mul_p[2*VAL_W-1:VAL_W];
			num_q[0] <= mul_p[VAL_W-1:0];
		end
		if (cmd.mul2) begin
			rem_q[1] <= mul_p[2*VAL_W-1:VAL_W];
			num_q[1] <= mul_p[VAL_W-1:0];
		end
		if (cmd.div_step) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= rem_n[l];
				num_q[l] <= num_n[l];
			end
		end
		if (cmd.finish) begin
			result_q.status        <= status_q;
			result_q.first_result  <= (status_q == STATUS_OK) ? res_v[0] : '0;
			result_q.second_result <= (status_q == STATUS_OK) ? res_v[1] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q       <= STATUS_OK;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.finish;
			if (cmd.load_query) begin
				status_q <= STATUS_OK;
			end else if (cmd.set_below) begin
				status_q <= STATUS_BELOW;
			end else if (cmd.set_above) begin
				status_q <= STATUS_ABOVE;
			end
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ===== hdl/piecewise_linear_table_interp.sv =====
// query: the scan reads entries from 0 up to i, the upper breakpoint index (1..n-1); below
// the first breakpoint it stops at entry 0, at or above the last at n-1 (n = point count)
// busy holds off the next query until the strobe cycle, which may take one; writes keep it low
// the query time comes from the one-entry-per-cycle scan of the table read port and the
// 32-step radix-2 divider; reset clears the sequencer, strobe and point count (to 2),
// table contents are undefined until written and are not cleared
module piecewise_linear_table_interp
	import plti_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// command side: a transaction is taken when start is high and busy is low
	input  logic               start,
	output logic               busy,
	input  in_t                item,
	// result side: one transaction per query, strobed for one cycle
	output out_t               result,
	output logic               result_valid,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_POINTS);

	logic [PC_W-1:0] point_count_q;
	logic [31:0]     pc_ext, last_ext;
	logic [AW-1:0]   last_idx;
	logic            is_query;
	ctrl_cmd_t       cmd;
	dp_stat_t        stat;

	// register port, single register, no wait states
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= PC_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_POINT_COUNT)) begin
			point_count_q <= pwdata[PC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_POINT_COUNT) begin
			prdata = PDATA_W'(point_count_q);
		end
	end

	// last scanned index: one below the point count clamped to two at least and the table size at most
	assign pc_ext = 32'(point_count_q);

	always_comb begin
		priority if (pc_ext < 32'd2) begin
			last_ext = 32'd1;
		end else if (pc_ext >= 32'(MAX_POINTS)) begin
			last_ext = 32'(MAX_POINTS - 1);
		end else begin
			last_ext = pc_ext - 32'd1;
		end
	end

	assign last_idx = last_ext[AW-1:0];
	assign is_query = (item.opcode == OP_QUERY);

	// sequencer: write in place, scan, difference, absolute value,
	// two shared multiplies, then both columns divided side by side
	plti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.is_query (is_query),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// table memory and arithmetic
	plti_dpath #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.last_idx     (last_idx),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== tb/piecewise_linear_table_interp_test.sv =====
// self-checking testbench for the two-column piecewise linear interpolation table
`timescale 1ns / 1ps

module piecewise_linear_table_interp_test;
	import plti_pkg::*;

	localparam int MAX_SLOTS    = 64;
	// no transaction of any kind for this many cycles means the block has hung
	localparam int STALL_LIMIT  = 3000;
	localparam int TARGET_ITEMS = 1070;
	localparam longint VAL_MAX  = 64'sh0000_0000_7FFF_FFFF;
	localparam longint VAL_MIN  = -VAL_MAX - 1;
	localparam logic signed [VAL_W-1:0] EDGE_LOW  = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] EDGE_HIGH = 32'sh7FFF_FFFF;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               busy;
	in_t                item    = '0;
	out_t               result;
	logic               result_valid;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// commands waiting for the driver, and lookups whose answers are still due
	in_t  command_queue [$];
	out_t pending_answers [$];

	// predictor copy of the table and the breakpoint count
	logic signed [VAL_W-1:0] model_pos    [MAX_SLOTS];
	logic signed [VAL_W-1:0] model_first  [MAX_SLOTS];
	logic signed [VAL_W-1:0] model_second [MAX_SLOTS];
	logic [PC_W-1:0]         model_count = PC_RESET;

	// generator view of breakpoint positions, as queued rather than as accepted
	logic signed [VAL_W-1:0] plan_pos [MAX_SLOTS];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int issued         = 0;
	int gap_left       = 0;
	bit gaps_on        = 1'b1;
	bit took           = 1'b0;

	piecewise_linear_table_interp #(
		.MAX_POINTS(MAX_SLOTS)
	) dut (
		.clk, .arst_n, .start, .busy, .item, .result, .result_valid,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// counts outside 2..64 behave as the nearest legal count
	function automatic int effective_count(logic [PC_W-1:0] c);
		if (c < 2) return 2;
		if (c > MAX_SLOTS) return MAX_SLOTS;
		return int'(c);
	endfunction

	// v0 + trunc(delta * (v1 - v0) / span), product kept exact in 128 bits
	function automatic logic signed [VAL_W-1:0] interpolate_column(
			logic signed [VAL_W-1:0] v0, logic signed [VAL_W-1:0] v1,
			logic [63:0] delta, logic [63:0] span);
		longint       dv, qv, res;
		bit           neg;
		logic [127:0] mag, quot;
		dv   = longint'(v1) - longint'(v0);
		neg  = dv < 0;
		mag  = neg ? 128'(-dv) : 128'(dv);
		quot = (mag * {64'd0, delta}) / {64'd0, span};
		if (quot > (128'd1 << 34)) quot = 128'd1 << 34;
		qv  = longint'(quot[63:0]);
		res = neg ? longint'(v0) - qv : longint'(v0) + qv;
		// saturate to Q16.16 range
		if (res > VAL_MAX) res = VAL_MAX;
		if (res < VAL_MIN) res = VAL_MIN;
		return res[VAL_W-1:0];
	endfunction

	// linear search for the first breakpoint above q, then interpolate both columns
	function automatic out_t predict_lookup(logic signed [VAL_W-1:0] q);
		out_t        answer;
		int          n, k;
		logic [63:0] delta, span;
		answer = '0;
		n = effective_count(model_count);
		if (q < model_pos[0]) begin
			answer.status = STATUS_BELOW;
			return answer;
		end
		k = 1;
		while (k < n && model_pos[k] <= q) k++;
		if (k >= n) begin
			answer.status = STATUS_ABOVE;
		end else begin
			delta = 64'(longint'(q) - longint'(model_pos[k-1]));
			span  = 64'(longint'(model_pos[k]) - longint'(model_pos[k-1]));
			answer.first_result  = interpolate_column(model_first[k-1], model_first[k],
				delta, span);
			answer.second_result = interpolate_column(model_second[k-1], model_second[k],
				delta, span);
			answer.status = STATUS_OK;
		end
		return answer;
	endfunction

	task automatic note_mismatch(string what, logic [$bits(out_t)-1:0] want_v,
			logic [$bits(out_t)-1:0] got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s at %0t: expected %h, got %h", what, $realtime,
				want_v, got_v);
	endtask

	// ---------------------------------------------------------------- driver

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// start is held until the block takes the transaction, then a random gap follows
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !took)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (command_queue.size() > 0) begin
				item     <= command_queue.pop_front();
				start    <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			took = start && !busy;
			// results first: an answer leaving now belongs to an older lookup
			if (result_valid) begin
				if (pending_answers.size() == 0) begin
					note_mismatch("result with nothing pending", '0, result);
				end else begin
					want = pending_answers.pop_front();
					if (result.first_result !== want.first_result)
						note_mismatch("first_result", 66'(want.first_result),
							66'(result.first_result));
					if (result.second_result !== want.second_result)
						note_mismatch("second_result", 66'(want.second_result),
							66'(result.second_result));
					if (result.status !== want.status)
						note_mismatch("status", 66'(want.status), 66'(result.status));
				end
			end
			if (took) begin
				if (item.opcode == OP_WRITE) begin
					model_pos[item.entry_index]    = item.entry_position;
					model_first[item.entry_index]  = item.entry_first_value;
					model_second[item.entry_index] = item.entry_second_value;
				end else begin
					pending_answers.push_back(predict_lookup(item.query_position));
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_POINT_COUNT)
				model_count = pwdata[PC_W-1:0];
			// watchdog on cycles without any transaction
			if (took || result_valid || (psel && penable && pready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic push_write(int slot, logic signed [VAL_W-1:0] pos,
			logic signed [VAL_W-1:0] v1, logic signed [VAL_W-1:0] v2);
		in_t t;
		t.opcode             = OP_WRITE;
		t.entry_index        = IDX_W'(slot);
		t.entry_position     = pos;
		t.entry_first_value  = v1;
		t.entry_second_value = v2;
		// ignored by a write, randomised so every bit moves
		t.query_position     = $urandom;
		command_queue.push_back(t);
		plan_pos[slot] = pos;
		issued++;
	endtask

	task automatic push_query(logic signed [VAL_W-1:0] q);
		in_t t;
		t.opcode             = OP_QUERY;
		t.entry_index        = IDX_W'($urandom);
		t.entry_position     = $urandom;
		t.entry_first_value  = $urandom;
		t.entry_second_value = $urandom;
		t.query_position     = q;
		command_queue.push_back(t);
		issued++;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return EDGE_LOW;
		if (r < 8) return EDGE_HIGH;
		if (r < 12) return '0;
		if (r < 15) return '1;
		if (r < 60) return $urandom;
		return VAL_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
	endfunction

	// mostly inside a segment, some at breakpoints, some off either end of the table
	function automatic logic signed [VAL_W-1:0] pick_query(int n);
		int     r, k;
		longint lo, hi;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			k  = $urandom_range(0, n - 2);
			lo = plan_pos[k];
			hi = plan_pos[k+1];
			if (hi > lo) begin
				if ($urandom_range(0, 9) == 0) return VAL_W'(hi - 1);
				return VAL_W'(lo + longint'($urandom) % (hi - lo));
			end
		end else if (r < 75) begin
			return plan_pos[$urandom_range(0, n - 1)];
		end else if (r < 84) begin
			lo = plan_pos[0];
			if (lo > VAL_MIN) begin
				if ($urandom_range(0, 3) == 0) return VAL_W'(lo - 1);
				return VAL_W'(VAL_MIN + longint'($urandom) % (lo - VAL_MIN));
			end
		end else if (r < 93) begin
			hi = plan_pos[n-1];
			if ($urandom_range(0, 3) == 0) return VAL_W'(hi);
			return VAL_W'(hi + longint'($urandom) % (VAL_MAX - hi + 1));
		end
		return $urandom;
	endfunction

	// strictly increasing positions over slots 0..n-1: wide, narrow or tightly packed
	task automatic load_table(int n, int style);
		logic signed [VAL_W-1:0] positions [MAX_SLOTS];
		longint step_max, base, pos;
		bit     descending;
		int     k, slot;
		case (style)
			0: begin
				step_max = 64'hFFFF_FFFF / n;
				base     = VAL_MIN + longint'($urandom) % step_max;
			end
			1: begin
				step_max = $urandom_range(2, 65536);
				base     = VAL_MIN + longint'($urandom) % (64'h1_0000_0000 - n * step_max);
			end
			default: begin
				step_max = 3;
				base     = VAL_MIN + longint'($urandom) % (64'h1_0000_0000 - n * step_max);
			end
		endcase
		pos = base;
		for (k = 0; k < n; k++) begin
			positions[k] = VAL_W'(pos);
			pos += $urandom_range(1, 32'(step_max));
		end
		descending = $urandom_range(0, 1);
		for (k = 0; k < n; k++) begin
			slot = descending ? n - 1 - k : k;
			push_write(slot, positions[slot], pick_value(), pick_value());
		end
	endtask

	// one register transaction; a read is checked against the predictor copy
	task automatic access_point_count(bit is_write, logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= ADDR_POINT_COUNT;
		if (is_write) pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (!is_write && prdata !== PDATA_W'(model_count))
			note_mismatch("point_count readback", 66'(model_count), 66'(prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every command is taken and every answer has come, then a short tail
	task automatic settle(int tail);
		while (command_queue.size() != 0 || start || pending_answers.size() != 0 || busy)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	function automatic int planned_count(int phase);
		int r;
		case (phase)
			0: return 3;
			1: return 64;
			2: return 0;
			3: return 127;
			4: return 1;
			5: return 65;
			6: return 2;
			7: return 9;
			default: begin
				r = $urandom_range(0, 9);
				if (r < 7) return $urandom_range(2, 16);
				if (r < 9) return $urandom_range(17, 64);
				return $urandom_range(0, 127);
			end
		endcase
	endfunction

	initial begin
		int setting, n, chunk, k, queries_left, phase, slot;
		logic [PDATA_W-1:0] reg_value;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset value of the count
		access_point_count(1'b0, '0);

		// directed part with the reset count of two
		// full-scale segment: both ends of the position range, opposite value extremes
		push_write(0, EDGE_LOW, EDGE_LOW, EDGE_HIGH);
		push_write(1, EDGE_HIGH, EDGE_HIGH, EDGE_LOW);
		push_query(EDGE_LOW);
		push_query(EDGE_HIGH - 1);
		push_query(EDGE_HIGH);
		push_query('0);
		// below the first breakpoint
		push_write(0, '0, '0, EDGE_HIGH);
		push_query('1);
		push_query(EDGE_LOW);
		// gap of one
		push_write(1, 32'sd1, EDGE_LOW, EDGE_HIGH);
		push_query('0);
		push_query(32'sd1);
		// positions out of order: the scan still stops at the first entry above the query
		push_write(0, 32'sd100, 32'sd5, -32'sd5);
		push_write(1, 32'sd50, -32'sd7, 32'sd7);
		push_query(32'sd120);
		push_query(32'sd60);
		push_query(32'sd99);
		// top slot, never read while the count is two
		push_write(MAX_SLOTS - 1, EDGE_HIGH, EDGE_LOW, EDGE_HIGH);
		settle(4);

		// random part: one count setting and one fresh table per phase
		phase = 0;
		while (issued < TARGET_ITEMS) begin
			setting   = planned_count(phase);
			reg_value = PDATA_W'(setting);
			if (phase % 2 == 1) reg_value[PDATA_W-1:PC_W] = $urandom;
			access_point_count(1'b1, reg_value);
			access_point_count(1'b0, '0);
			n = effective_count(PC_W'(setting));
			gaps_on = 1'b1;
			load_table(n, $urandom_range(0, 2));
			queries_left = $urandom_range(40, 90);
			while (queries_left > 0) begin
				chunk   = $urandom_range(8, 30);
				// some chunks run back to back with no idle cycles at all
				gaps_on = $urandom_range(0, 3) != 0;
				for (k = 0; k < chunk && queries_left > 0; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						// noise: value refresh, or a position that may break the ordering
						case ($urandom_range(0, 3))
							0, 1: begin
								slot = $urandom_range(0, n - 1);
								push_write(slot, plan_pos[slot], pick_value(), pick_value());
							end
							2: push_write($urandom_range(0, n - 1), $urandom, pick_value(),
								pick_value());
							default: push_write($urandom_range(0, MAX_SLOTS - 1), $urandom,
								pick_value(), pick_value());
						endcase
					end else begin
						push_query(pick_query(n));
					end
					queries_left--;
				end
				// at times the sender holds off until the block has answered everything
				if ($urandom_range(0, 3) == 0) settle(0);
			end
			settle(4);
			phase++;
		end

		settle(0);
		repeat (120) @(posedge clk);
		if (mismatch_count == 0 && pending_answers.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/plti_pkg.sv
hdl/plti_ctrl.sv
hdl/plti_dpath.sv
hdl/piecewise_linear_table_interp.sv
tb/piecewise_linear_table_interp_test.sv
